/* rtl/core/lpcf_pkg.sv */
// ----------------------------------------------------------------------------
// lpcf_pkg
// Shared constants and types for the local peak clip filter.
// ----------------------------------------------------------------------------
package lpcf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int PIX_BITS   = 16;
    localparam int FW_BITS    = 11;
    localparam int COL_BITS   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CMP_BITS   = (COL_BITS + 1 > FW_BITS) ? COL_BITS + 1 : FW_BITS;
    localparam logic [FW_BITS-1:0] FW_RESET = FW_BITS'(1024);

    // word commands
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // access to the two line stores for one word
    typedef struct packed {
        logic                rd_en;
        logic [COL_BITS-1:0] rd_addr;
        logic                wr_en;
        logic [COL_BITS-1:0] wr_addr;
        logic                wr_sel;     // 0: store a, 1: store b
        logic [PIX_BITS-1:0] wr_data;
    } t_mem_req;

    // one pixel handed to the compare stage
    typedef struct packed {
        logic [PIX_BITS-1:0] v;
        logic [PIX_BITS-1:0] up;
        logic [PIX_BITS-1:0] pix;
        logic [PIX_BITS-1:0] left;
        logic                has_up;
        logic                has_below;
        logic                has_left;
        logic                has_right;
        logic                prev_sel;   // selects the centre row: 1 for store a, 0 for store b
        logic                frame_last;
    } t_tap;

endpackage

/* rtl/core/local_peak_clip_filter_core.sv */
// ----------------------------------------------------------------------------
// local_peak_clip_filter_core
// Four-neighbour local maximum clipping over a raster pixel stream.
// ----------------------------------------------------------------------------
// Takes one word per clock while o_in_ready is high. A result passes the compare
// and output registers and belongs to the row above: (r,c) in, (r-1,c) out.
// Close a frame with frame_width flush words, which emit the bottom row.
// The two rows are kept in two 1024 x 16 synchronous stores read one column
// ahead, so the right neighbour is ready the cycle after the word enters;
// the store contents are undefined after reset and need no clearing pass.
// Write frame_width between frames only.
// ----------------------------------------------------------------------------
module local_peak_clip_filter_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lpcf_pkg::FW_BITS-1:0]  i_cfg_frame_width,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_cmd,
    input  logic [lpcf_pkg::PIX_BITS-1:0] i_pixel_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [lpcf_pkg::PIX_BITS-1:0] o_pixel_out,
    output logic                          o_was_clipped,
    output logic                          o_frame_last
);

    logic [lpcf_pkg::FW_BITS-1:0]  r_width;
    logic [lpcf_pkg::COL_BITS-1:0] r_col;
    logic [lpcf_pkg::COL_BITS-1:0] n_col;
    logic [1:0]                    r_rows;
    logic [1:0]                    n_rows;
    logic                          r_sel;
    logic                          n_sel;
    logic                          r_flushing;
    logic                          n_flushing;
    logic [lpcf_pkg::PIX_BITS-1:0] r_left;

    logic                          acc;
    logic                          ignored;
    logic                          active;
    logic                          flush_now;
    logic                          last_col;
    logic [lpcf_pkg::CMP_BITS-1:0] w_eff;
    logic [lpcf_pkg::COL_BITS-1:0] col_inc;
    logic [lpcf_pkg::PIX_BITS-1:0] rd_a;
    logic [lpcf_pkg::PIX_BITS-1:0] rd_b;
    logic [lpcf_pkg::PIX_BITS-1:0] prev_v;
    logic [lpcf_pkg::PIX_BITS-1:0] cur_v;
    logic                          s1_ready;
    logic                          load;
    lpcf_pkg::t_mem_req            req;
    lpcf_pkg::t_tap                tap;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= lpcf_pkg::FW_RESET;
        end else if (i_cfg_valid) begin
            r_width <= i_cfg_frame_width;
        end
    end

    always_comb begin
        if (r_width == '0) begin
            w_eff = lpcf_pkg::CMP_BITS'(1);
        end else if (lpcf_pkg::CMP_BITS'(r_width) > lpcf_pkg::CMP_BITS'(lpcf_pkg::MAX_WIDTH)) begin
            w_eff = lpcf_pkg::CMP_BITS'(lpcf_pkg::MAX_WIDTH);
        end else begin
            w_eff = lpcf_pkg::CMP_BITS'(r_width);
        end
    end

    assign o_in_ready = s1_ready;
    assign acc        = i_in_valid && s1_ready;
    assign ignored    = flush_now ? (!r_flushing && ((r_rows == 2'd0) || (r_col != '0)))
                                  : r_flushing;
    assign active     = acc && !ignored;
    assign flush_now  = (i_cmd == lpcf_pkg::CMD_FLUSH);
    assign last_col   = (lpcf_pkg::CMP_BITS'(r_col) + lpcf_pkg::CMP_BITS'(1)) >= w_eff;
    assign col_inc    = lpcf_pkg::COL_BITS'(r_col + 1'b1);

    assign prev_v = r_sel ? rd_a : rd_b;
    assign cur_v  = r_sel ? rd_b : rd_a;

    always_comb begin
        n_col      = r_col;
        n_rows     = r_rows;
        n_sel      = r_sel;
        n_flushing = r_flushing;
        if (active) begin
            n_col = last_col ? '0 : col_inc;
            if (flush_now) begin
                n_flushing = !last_col;
                if (last_col) begin
                    n_rows = 2'd0;
                end
            end else if (last_col) begin
                n_sel = !r_sel;
                if (r_rows != 2'd2) begin
                    n_rows = r_rows + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_rows     <= 2'd0;
            r_sel      <= 1'b0;
            r_flushing <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_rows     <= n_rows;
            r_sel      <= n_sel;
            r_flushing <= n_flushing;
        end
    end

    always_ff @(posedge i_clk) begin
        if (active) begin
            r_left <= prev_v;
        end
    end

    always_comb begin
        req.rd_en   = active;
        req.rd_addr = last_col ? '0 : col_inc;
        req.wr_en   = active && !flush_now;
        req.wr_addr = r_col;
        req.wr_sel  = r_sel;
        req.wr_data = i_pixel_in;
    end

    always_comb begin
        tap.v          = prev_v;
        tap.up         = cur_v;
        tap.pix        = i_pixel_in;
        tap.left       = r_left;
        tap.has_up     = r_rows[1];
        tap.has_below  = !flush_now;
        tap.has_left   = (r_col != '0);
        tap.has_right  = !last_col;
        tap.prev_sel   = r_sel;
        tap.frame_last = flush_now && last_col;
    end

    assign load = active && (r_rows != 2'd0);

    lpcf_line_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rd_a  (rd_a),
        .o_rd_b  (rd_b)
    );

    lpcf_peak_unit u_peak (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (load),
        .i_tap         (tap),
        .i_rd_a        (rd_a),
        .i_rd_b        (rd_b),
        .o_s1_ready    (s1_ready),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_out   (o_pixel_out),
        .o_was_clipped (o_was_clipped),
        .o_frame_last  (o_frame_last)
    );

    a_flush_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (active && flush_now && last_col) |=> (r_col == '0 && r_rows == 2'd0 && !r_flushing))
        else $error("flush did not return to start of frame");

    a_flush_has_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flushing |-> (r_rows != 2'd0))
        else $error("flushing with no stored row");

    a_row_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (active && !flush_now && last_col) |=> (r_sel != $past(r_sel)))
        else $error("row stores not swapped at end of row");

    a_no_write_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flushing |-> !req.wr_en)
        else $error("line store written while flushing");

endmodule

/* rtl/core/lpcf_line_mem.sv */
// ----------------------------------------------------------------------------
// lpcf_line_mem
// Two row stores, one write and one registered read each, same-entry
// write/read forwarding.
// ----------------------------------------------------------------------------
module lpcf_line_mem (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lpcf_pkg::t_mem_req           i_req,
    output logic [lpcf_pkg::PIX_BITS-1:0] o_rd_a,
    output logic [lpcf_pkg::PIX_BITS-1:0] o_rd_b
);

    logic [lpcf_pkg::PIX_BITS-1:0] mem_a [lpcf_pkg::MAX_WIDTH];
    logic [lpcf_pkg::PIX_BITS-1:0] mem_b [lpcf_pkg::MAX_WIDTH];

    logic [lpcf_pkg::PIX_BITS-1:0] r_rd_a;
    logic [lpcf_pkg::PIX_BITS-1:0] r_rd_b;
    logic [lpcf_pkg::PIX_BITS-1:0] r_fwd_data;
    logic                          r_fwd_sel;
    logic                          r_fwd_hit;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en && !i_req.wr_sel) begin
            mem_a[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.wr_en && i_req.wr_sel) begin
            mem_b[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_a     <= mem_a[i_req.rd_addr];
            r_rd_b     <= mem_b[i_req.rd_addr];
            r_fwd_data <= i_req.wr_data;
            r_fwd_sel  <= i_req.wr_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (i_req.rd_en) begin
            r_fwd_hit <= i_req.wr_en && (i_req.wr_addr == i_req.rd_addr);
        end
    end

    assign o_rd_a = (r_fwd_hit && !r_fwd_sel) ? r_fwd_data : r_rd_a;
    assign o_rd_b = (r_fwd_hit &&  r_fwd_sel) ? r_fwd_data : r_rd_b;

endmodule

/* rtl/core/lpcf_peak_unit.sv */
// ----------------------------------------------------------------------------
// lpcf_peak_unit
// Compare stage and output register: peak test against the present
// neighbours, clipping to their maximum.
// ----------------------------------------------------------------------------
module lpcf_peak_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  lpcf_pkg::t_tap                i_tap,
    input  logic [lpcf_pkg::PIX_BITS-1:0] i_rd_a,
    input  logic [lpcf_pkg::PIX_BITS-1:0] i_rd_b,
    output logic                          o_s1_ready,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [lpcf_pkg::PIX_BITS-1:0] o_pixel_out,
    output logic                          o_was_clipped,
    output logic                          o_frame_last
);

    lpcf_pkg::t_tap                r_s1;
    logic                          r_s1_v;
    logic                          r_out_v;
    logic [lpcf_pkg::PIX_BITS-1:0] r_pix_out;
    logic                          r_clip;
    logic                          r_last;

    logic                          out_load;
    logic [lpcf_pkg::PIX_BITS-1:0] right;
    logic [lpcf_pkg::PIX_BITS-1:0] nb  [4];
    logic                          has [4];
    logic                          peak;
    logic [lpcf_pkg::PIX_BITS-1:0] mx;

    assign out_load   = r_s1_v && (!r_out_v || i_out_ready);
    assign o_s1_ready = !r_s1_v || out_load;

    // right neighbour arrives from the read issued with this word
    assign right = r_s1.prev_sel ? i_rd_a : i_rd_b;

    always_comb begin
        nb[0]  = r_s1.up;
        nb[1]  = r_s1.pix;
        nb[2]  = r_s1.left;
        nb[3]  = right;
        has[0] = r_s1.has_up;
        has[1] = r_s1.has_below;
        has[2] = r_s1.has_left;
        has[3] = r_s1.has_right;
        peak   = 1'b1;
        mx     = '0;
        for (int i = 0; i < 4; i++) begin
            if (has[i]) begin
                if (r_s1.v > nb[i]) begin
                    if (nb[i] > mx) begin
                        mx = nb[i];
                    end
                end else begin
                    peak = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (i_load) begin
                r_s1_v <= 1'b1;
            end else if (out_load) begin
                r_s1_v <= 1'b0;
            end
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s1 <= i_tap;
        end
        if (out_load) begin
            r_pix_out <= peak ? mx : r_s1.v;
            r_clip    <= peak;
            r_last    <= r_s1.frame_last;
        end
    end

    assign o_out_valid   = r_out_v;
    assign o_pixel_out   = r_pix_out;
    assign o_was_clipped = r_clip;
    assign o_frame_last  = r_last;

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_s1_ready)
        else $error("compare stage overwritten");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && !out_load) |=> r_s1_v)
        else $error("compare stage dropped a word");

    a_out_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_out_v)
        else $error("result not registered");

endmodule
